// File: hw/rtl/baba_pkg.sv
// shared types and constants for the bus address bitmap allocator
// no dependencies; imported by every module of the block
`default_nettype none

package baba_pkg;

  localparam int ID_W = 8;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [ID_W-1:0] NO_FREE = 8'hFF;
  localparam logic [ID_W-1:0] RESET_MAX_ID = 8'd247;
  localparam logic [ID_W-1:0] RESET_BCAST_ID = 8'd0;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_REINIT  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ID   = 1'b0,
    CFG_BCAST_ID = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic            fire;
    cmd_t            cmd;
    logic [ID_W-1:0] id;
  } map_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/baba_ffz.sv
// find-first-zero encoder over the used map
// depends on baba_pkg for the id width and the no-free code
`default_nettype none

module baba_ffz #(
  parameter int ID_COUNT = 256
) (
  input  wire logic [ID_COUNT-1:0]       map,
  output logic [baba_pkg::ID_W-1:0]      free_id,
  output logic                           none_free
);
  import baba_pkg::*;

  logic [ID_COUNT-1:0] lowest_zero;
  logic [ID_W-1:0]     idx;

  // isolate the lowest clear bit
  assign lowest_zero = ~map & (map + ID_COUNT'(1));

  always_comb begin
    idx = '0;
    for (int b = 0; b < ID_COUNT; b++) begin
      if (lowest_zero[b]) begin
        idx = idx | ID_W'(b);
      end
    end
  end

  assign none_free = &map;
  assign free_id   = none_free ? NO_FREE : idx;

endmodule

`default_nettype wire

// File: hw/rtl/baba_map.sv
// used map register with mark, release and reinit update
// depends on baba_pkg for the command codes and the request struct
`default_nettype none

module baba_map #(
  parameter int ID_COUNT = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire baba_pkg::map_req_t          req,
  input  wire logic [baba_pkg::ID_W-1:0]   max_id,
  input  wire logic [baba_pkg::ID_W-1:0]   bcast_id,
  output logic [ID_COUNT-1:0]              map_nxt,
  output logic                             was_used
);
  import baba_pkg::*;

  localparam int IDX_W = $clog2(ID_COUNT);

  logic [ID_COUNT-1:0] map_r;
  logic [ID_COUNT-1:0] map_upd;
  logic                in_range;
  logic [IDX_W-1:0]    idx;

  function automatic logic [ID_COUNT-1:0] rebuild(logic [ID_W-1:0] mx, logic [ID_W-1:0] bc);
    logic [ID_COUNT-1:0] m;
    for (int a = 0; a < ID_COUNT; a++) begin
      m[a] = ((ID_W+1)'(a) >= {1'b0, mx}) || ((ID_W+1)'(a) == {1'b0, bc});
    end
    return m;
  endfunction

  assign in_range = {1'b0, req.id} < (ID_W+1)'(ID_COUNT);
  assign idx      = req.id[IDX_W-1:0];
  // ids outside the bus always read as used
  assign was_used = in_range ? map_r[idx] : 1'b1;

  always_comb begin
    map_upd = map_r;
    case (req.cmd)
      CMD_MARK: begin
        if (in_range) map_upd[idx] = 1'b1;
      end
      CMD_RELEASE: begin
        if (in_range) map_upd[idx] = 1'b0;
      end
      CMD_REINIT: begin
        map_upd = rebuild(max_id, bcast_id);
      end
      default: begin
      end
    endcase
    map_nxt = req.fire ? map_upd : map_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= rebuild(RESET_MAX_ID, RESET_BCAST_ID);
    end else begin
      map_r <= map_nxt;
    end
  end

  a_mark_sets: assert property (@(posedge clk) disable iff (!rst_n)
    req.fire && req.cmd == CMD_MARK && in_range |=> map_r[$past(idx)])
    else $error("marked id not set in map");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    req.fire && req.cmd == CMD_RELEASE && in_range |=> !map_r[$past(idx)])
    else $error("released id still set in map");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !req.fire |=> map_r == $past(map_r))
    else $error("map changed without an item");

endmodule

`default_nettype wire

// File: hw/rtl/bus_address_bitmap_allocator.sv
// top level of the bus address bitmap allocator: handshake registers and config
// depends on baba_pkg, baba_map and baba_ffz
//
// usage:
//   input channel  in_valid / in_stall carries cmd and id; an item is taken
//   at a rising edge with in_valid high and in_stall low
//   result channel out_valid / out_stall carries free_id, none_free, was_used
//   config port    cfg_we, cfg_index, cfg_data; index 0 is max_id, 1 is
//   broadcast_id; a new value only takes effect at the next reinit command
// timing:
//   one item per cycle sustained while out_stall is low; the result is
//   registered as the item leaves the input register, when the result side is free
//   the map update and the 256-bit lowest-free search are both combinational
//   between the input register and the result register
// reset:
//   rst_n low clears both channel registers, loads max_id 247 and
//   broadcast_id 0 and rebuilds the map as a reinit would
// stall:
//   a held result keeps its value; one more item waits in the input register,
//   after which in_stall follows out_stall
`default_nettype none

module bus_address_bitmap_allocator #(
  parameter int ID_COUNT = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire baba_pkg::cmd_t                 in_cmd,
  input  wire logic [baba_pkg::ID_W-1:0]      in_id,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [baba_pkg::ID_W-1:0]           out_free_id,
  output logic                                out_none_free,
  output logic                                out_was_used,
  input  wire logic                           cfg_we,
  input  wire logic [baba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [baba_pkg::CFG_W-1:0]     cfg_data
);
  import baba_pkg::*;

  logic              s_valid_r;
  cmd_t              s_cmd_r;
  logic [ID_W-1:0]   s_id_r;
  logic              out_valid_r;
  logic [ID_W-1:0]   free_id_r;
  logic              none_free_r;
  logic              was_used_r;
  logic [ID_W-1:0]   max_id_r;
  logic [ID_W-1:0]   bcast_id_r;

  logic              out_free;
  logic              fire;
  logic              in_take;
  map_req_t          req;
  logic [ID_COUNT-1:0] map_nxt;
  logic              was_used;
  logic [ID_W-1:0]   free_id;
  logic              none_free;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s_valid_r && out_free;
  assign in_stall = s_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign req.fire = fire;
  assign req.cmd  = s_cmd_r;
  assign req.id   = s_id_r;

  baba_map #(.ID_COUNT(ID_COUNT)) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .max_id   (max_id_r),
    .bcast_id (bcast_id_r),
    .map_nxt  (map_nxt),
    .was_used (was_used)
  );

  baba_ffz #(.ID_COUNT(ID_COUNT)) u_ffz (
    .map       (map_nxt),
    .free_id   (free_id),
    .none_free (none_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      max_id_r    <= RESET_MAX_ID;
      bcast_id_r  <= RESET_BCAST_ID;
    end else begin
      if (in_take) begin
        s_valid_r <= 1'b1;
      end else if (fire) begin
        s_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_ID:   max_id_r   <= cfg_data;
          CFG_BCAST_ID: bcast_id_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_cmd_r <= in_cmd;
      s_id_r  <= in_id;
    end
    if (fire) begin
      free_id_r   <= free_id;
      none_free_r <= none_free;
      was_used_r  <= was_used;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_free_id   = free_id_r;
  assign out_none_free = none_free_r;
  assign out_was_used  = was_used_r;

  a_none_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && none_free_r |-> free_id_r == NO_FREE)
    else $error("none_free without the no-free code");

  a_free_in_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !none_free_r |-> {1'b0, free_id_r} < (ID_W+1)'(ID_COUNT))
    else $error("free id outside the bus");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && !out_free |=> s_valid_r && $stable(s_cmd_r) && $stable(s_id_r))
    else $error("input register lost a stalled item");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s_valid_r && out_valid_r)
    else $error("stall raised with room in the pipeline");

endmodule

`default_nettype wire
